// ----- design/bvab_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bvab_pkg
// Shared types and constants for the battery voltage averaging block.
// ----------------------------------------------------------------------------
package bvab_pkg;

    localparam int WINDOW_DEF = 20;

    localparam int CODE_W = 12;
    localparam int MV_W   = 17;
    localparam int BAND_W = 2;

    // Quotient bits of the divider; the average never exceeds full scale.
    localparam int Q_W    = MV_W;
    localparam int STEP_W = $clog2(Q_W);

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [MV_W-1:0] FULL_SCALE_RST = MV_W'(69300);
    localparam logic [MV_W-1:0] HIGH_THR_RST   = MV_W'(22200);
    localparam logic [MV_W-1:0] LOW_THR_RST    = MV_W'(20400);

    localparam logic [1:0] REG_FULL_SCALE = 2'd0;
    localparam logic [1:0] REG_HIGH_THR   = 2'd1;
    localparam logic [1:0] REG_LOW_THR    = 2'd2;

    localparam logic [BAND_W-1:0] BAND_HIGH = 2'd0;
    localparam logic [BAND_W-1:0] BAND_MID  = 2'd1;
    localparam logic [BAND_W-1:0] BAND_LOW  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [MV_W-1:0] full_scale_mv;
        logic [MV_W-1:0] high_threshold_mv;
        logic [MV_W-1:0] low_threshold_mv;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic update;
        logic mul;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_stat;

endpackage
`default_nettype wire

// ----- design/bvab_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bvab_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module bvab_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 20,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- design/bvab_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bvab_cfg
// APB register file: full scale and the two band thresholds.
// ----------------------------------------------------------------------------
module bvab_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bvab_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [bvab_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [bvab_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready,
    output bvab_pkg::t_cfg                       o_cfg
);
    import bvab_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_scale_mv     <= FULL_SCALE_RST;
            r_cfg.high_threshold_mv <= HIGH_THR_RST;
            r_cfg.low_threshold_mv  <= LOW_THR_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FULL_SCALE: r_cfg.full_scale_mv     <= pwdata[MV_W-1:0];
                REG_HIGH_THR:   r_cfg.high_threshold_mv <= pwdata[MV_W-1:0];
                REG_LOW_THR:    r_cfg.low_threshold_mv  <= pwdata[MV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FULL_SCALE: prdata = CFG_DATA_W'(r_cfg.full_scale_mv);
            REG_HIGH_THR:   prdata = CFG_DATA_W'(r_cfg.high_threshold_mv);
            REG_LOW_THR:    prdata = CFG_DATA_W'(r_cfg.low_threshold_mv);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- design/bvab_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bvab_ctrl
// Sequencer: accept, ring update, multiply, serial divide, output load.
// ----------------------------------------------------------------------------
module bvab_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  wire logic            i_stall,
    input  bvab_pkg::t_stat      i_stat,
    output bvab_pkg::t_cmd       o_cmd
);
    import bvab_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_MUL;
            S_MUL:    n_state = S_DIV;
            S_DIV: begin
                if (i_stat.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            S_UPDATE: o_cmd.update   = 1'b1;
            S_MUL:    o_cmd.mul      = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_DONE:   o_cmd.load_out = out_free;
            default: ;
        endcase
    end

    // A load in the same cycle as a take keeps the output valid.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

// ----- design/bvab_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bvab_dp
// Datapath: sample ring, running sum, multiplier and restoring divider.
// ----------------------------------------------------------------------------
module bvab_dp #(
    parameter int WINDOW = bvab_pkg::WINDOW_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  bvab_pkg::t_cmd                   i_cmd,
    input  bvab_pkg::t_cfg                   i_cfg,
    input  wire logic [bvab_pkg::CODE_W-1:0] i_adc_code,
    output bvab_pkg::t_stat                  o_stat,
    output logic      [bvab_pkg::MV_W-1:0]   o_voltage_mv,
    output logic      [bvab_pkg::BAND_W-1:0] o_band
);
    import bvab_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = CODE_W + CNT_W;
    localparam int DEN_W = CODE_W + CNT_W;
    localparam int NUM_W = SUM_W + MV_W;

    logic [CODE_W-1:0] r_code;
    logic [IDX_W-1:0]  r_widx;
    logic [CNT_W-1:0]  r_count;
    logic [SUM_W-1:0]  r_sum;
    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_dvs;
    logic [Q_W-1:0]    r_quo;
    logic [STEP_W-1:0] r_step;
    logic [MV_W-1:0]   r_volt;
    logic [BAND_W-1:0] r_band;

    logic [CODE_W-1:0] old_code;
    logic              ring_full;
    logic              idx_last;
    logic [SUM_W-1:0]  n_sum;
    logic [DEN_W-1:0]  den;
    logic              fits;

    bvab_ram #(
        .WIDTH(CODE_W),
        .DEPTH(WINDOW),
        .AW   (IDX_W)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (i_cmd.update),
        .i_waddr(r_widx),
        .i_wdata(r_code),
        .i_raddr(r_widx),
        .o_rdata(old_code)
    );

    assign ring_full = (r_count == CNT_W'(WINDOW));
    assign idx_last  = (r_widx == IDX_W'(WINDOW - 1));

    // The oldest code leaves the sum only once the ring has wrapped.
    assign n_sum = r_sum - (ring_full ? SUM_W'(old_code) : SUM_W'(0)) + SUM_W'(r_code);

    // 4095 * count as a shift and a subtract.
    assign den  = DEN_W'({r_count, CODE_W'(0)}) - DEN_W'(r_count);
    assign fits = (r_rem >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx  <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_cmd.update) begin
            r_widx  <= idx_last ? IDX_W'(0) : r_widx + IDX_W'(1);
            r_count <= ring_full ? r_count : r_count + CNT_W'(1);
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_code <= i_adc_code;
        end
        if (i_cmd.mul) begin
            r_rem  <= NUM_W'(r_sum) * NUM_W'(i_cfg.full_scale_mv);
            r_dvs  <= NUM_W'(den) << (Q_W - 1);
            r_quo  <= '0;
            r_step <= STEP_W'(Q_W - 1);
        end else if (i_cmd.div_step) begin
            if (fits) begin
                r_rem <= r_rem - r_dvs;
            end
            r_dvs  <= r_dvs >> 1;
            r_quo  <= {r_quo[Q_W-2:0], fits};
            r_step <= r_step - STEP_W'(1);
        end
        if (i_cmd.load_out) begin
            r_volt <= r_quo;
            if (r_quo > i_cfg.high_threshold_mv) begin
                r_band <= BAND_HIGH;
            end else if (r_quo > i_cfg.low_threshold_mv) begin
                r_band <= BAND_MID;
            end else begin
                r_band <= BAND_LOW;
            end
        end
    end

    assign o_stat.div_last = (r_step == STEP_W'(0));
    assign o_voltage_mv    = r_volt;
    assign o_band          = r_band;

endmodule
`default_nettype wire

// ----- design/battery_voltage_average_band_select.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// battery_voltage_average_band_select
// Windowed average of battery ADC codes in millivolts with band selection.
// ----------------------------------------------------------------------------
// Each accepted 12-bit code enters a ring of the last WINDOW samples and yields
// one result: the average voltage floor(sum * full_scale_mv / (4095 * count))
// over the samples held so far, and a band code (0 above the high threshold,
// 1 above the low threshold, 2 otherwise; equality selects the lower band).
// Each item passes through an accept step, a ring update that reads the oldest
// sample from the ring memory, a multiply step, the bit-serial restoring
// divider, one quotient bit per cycle, and then the output load. The finished
// result waits in an output register, so o_stall drops again as soon as the
// result is loaded. The ring needs no clearing after reset; a sample is read
// only once written.
// ----------------------------------------------------------------------------
module battery_voltage_average_band_select #(
    parameter int WINDOW = bvab_pkg::WINDOW_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [bvab_pkg::CODE_W-1:0]     i_adc_code,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [bvab_pkg::MV_W-1:0]       o_voltage_mv,
    output logic      [bvab_pkg::BAND_W-1:0]     o_band,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bvab_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [bvab_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [bvab_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import bvab_pkg::*;

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    bvab_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (cfg)
    );

    bvab_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    bvab_dp #(
        .WINDOW(WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_adc_code  (i_adc_code),
        .o_stat      (stat),
        .o_voltage_mv(o_voltage_mv),
        .o_band      (o_band)
    );

endmodule
`default_nettype wire
